// ===== rtl/core/sgt_pkg.sv =====
// Shared types, codes and default sizes of the sparse grouped table.
package sgt_pkg;

	// Default sizes handed to the top level parameters.
	localparam int GROUP_SHIFT_DEF = 8;
	localparam int MAX_GROUPS_DEF  = 64;
	localparam int POOL_GROUPS_DEF = 16;
	localparam int VALUE_WIDTH_DEF = 32;

	// Window registers and their reset values.
	localparam int          CFG_INDEX_W  = 4;
	localparam logic [3:0]  REG_FIRST    = 4'd0;
	localparam logic [3:0]  REG_LAST     = 4'd1;
	localparam logic [31:0] FIRST_RESET  = 32'd0;
	localparam logic [31:0] LAST_RESET   = 32'd16383;

	// Operation codes.
	localparam logic [1:0] MODE_GET   = 2'd0;
	localparam logic [1:0] MODE_SET   = 2'd1;
	localparam logic [1:0] MODE_CLEAR = 2'd2;

	// Status codes.
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_RANGE  = 2'd1;
	localparam logic [1:0] ST_NODATA = 2'd2;
	localparam logic [1:0] ST_NOMEM  = 2'd3;

	typedef struct packed {
		logic [1:0]  mode;
		logic [31:0] index;
		logic [31:0] write_value;
	} sgt_req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] read_value;
	} sgt_rsp_t;

	// Write strobes for the entry store.
	typedef struct packed {
		logic value_we;
		logic row_we;
	} sgt_wr_t;

endpackage

// ===== rtl/core/sgt_store.sv =====
// Entry store: value memory and valid-bit row memory, both with registered reads.
module sgt_store #(
	parameter int GROUP_SHIFT = sgt_pkg::GROUP_SHIFT_DEF,
	parameter int POOL_GROUPS = sgt_pkg::POOL_GROUPS_DEF,
	parameter int VALUE_WIDTH = sgt_pkg::VALUE_WIDTH_DEF,
	localparam int BLK_W   = (POOL_GROUPS > 1) ? $clog2(POOL_GROUPS) : 1,
	localparam int FLAT_W  = BLK_W + GROUP_SHIFT,
	localparam int VSH     = (GROUP_SHIFT < 6) ? GROUP_SHIFT : 6,
	localparam int ROW_W   = 1 << VSH,
	localparam int ROW_AW  = FLAT_W - VSH
) (
	input  logic                   clk,
	input  sgt_pkg::sgt_wr_t       wr,
	input  logic [FLAT_W-1:0]      val_addr,
	input  logic [VALUE_WIDTH-1:0] val_wdata,
	output logic [VALUE_WIDTH-1:0] val_rdata,
	input  logic [ROW_AW-1:0]      row_addr,
	input  logic [ROW_W-1:0]       row_wdata,
	output logic [ROW_W-1:0]       row_rdata
);
	import sgt_pkg::*;

	localparam int ENTRIES = POOL_GROUPS << GROUP_SHIFT;
	localparam int ROWS    = ENTRIES >> VSH;

	logic [VALUE_WIDTH-1:0] val_mem [ENTRIES];
	logic [ROW_W-1:0]       row_mem [ROWS];

	always_ff @(posedge clk) begin
		if (wr.value_we) begin
			val_mem[val_addr] <= val_wdata;
		end
		val_rdata <= val_mem[val_addr];
	end

	always_ff @(posedge clk) begin
		if (wr.row_we) begin
			row_mem[row_addr] <= row_wdata;
		end
		row_rdata <= row_mem[row_addr];
	end

endmodule

// ===== rtl/core/sparse_grouped_table_core.sv =====
// Sparse grouped table: window check, group map, block pool and entry access.
//
//   Channel  Signals                                    Direction  Payload
//   req      req_valid, req_ready, req                  in         mode, index, write_value
//   rsp      rsp_valid, rsp_ready, rsp                  out        status, read_value
//   cfg      cfg_valid, cfg_ready, cfg_index, cfg_data  in         window registers 0 and 1
//
// One request is worked on at a time. A get with a present group passes S_CHECK,
// S_MAP and S_READ before the result register loads in S_RESP, a set into a present
// group S_CHECK, S_MAP and S_SETWR, a get or set that stops at the group map (absent
// group, no free block) S_CHECK and S_MAP, and a clear, an unused mode or a range
// error S_CHECK alone. A set that takes a new block adds a wipe of its valid rows,
// 2**(GROUP_SHIFT-min(GROUP_SHIFT,6)) of them in S_WIPE, and a re-read in S_FETCH.
// Reset loads the window registers with their reset values and clears the presence
// flags and the pool counter; the memories are not cleared. A waiting result does
// not stop the next transfer on req; the following result then holds in its final
// state until rsp drains.
module sparse_grouped_table_core #(
	parameter int GROUP_SHIFT = sgt_pkg::GROUP_SHIFT_DEF,
	parameter int MAX_GROUPS  = sgt_pkg::MAX_GROUPS_DEF,
	parameter int POOL_GROUPS = sgt_pkg::POOL_GROUPS_DEF,
	parameter int VALUE_WIDTH = sgt_pkg::VALUE_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_valid,
	output logic                                req_ready,
	input  sgt_pkg::sgt_req_t                   req,
	output logic                                rsp_valid,
	input  logic                                rsp_ready,
	output sgt_pkg::sgt_rsp_t                   rsp,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [sgt_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [31:0]                         cfg_data
);
	import sgt_pkg::*;

	localparam int GRP_W   = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
	localparam int BLK_W   = (POOL_GROUPS > 1) ? $clog2(POOL_GROUPS) : 1;
	localparam int NF_W    = $clog2(POOL_GROUPS + 1);
	localparam int FLAT_W  = BLK_W + GROUP_SHIFT;
	localparam int VSH     = (GROUP_SHIFT < 6) ? GROUP_SHIFT : 6;
	localparam int ROW_W   = 1 << VSH;
	localparam int ROW_AW  = FLAT_W - VSH;
	localparam int WIPE_W  = GROUP_SHIFT - VSH + 1;
	localparam int HI_W    = 32 - GROUP_SHIFT;
	localparam logic [WIPE_W-1:0] WIPE_LAST = WIPE_W'((1 << (GROUP_SHIFT - VSH)) - 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_MAP,
		S_WIPE,
		S_FETCH,
		S_READ,
		S_SETWR,
		S_RESP
	} state_t;

	state_t               state_q;
	sgt_req_t             item_q;
	logic [31:0]          first_q;
	logic [31:0]          last_q;
	logic [MAX_GROUPS-1:0] present_q;
	logic [NF_W-1:0]      next_free_q;
	logic [GRP_W-1:0]     grp_q;
	logic [GROUP_SHIFT-1:0] pos_q;
	logic [FLAT_W-1:0]    flat_q;
	logic [WIPE_W-1:0]    wipe_q;
	logic [1:0]           status_q;
	logic [31:0]          rval_q;
	logic                 rsp_valid_q;
	sgt_rsp_t             rsp_q;

	// Group map memory: pool block of each group, with a registered read.
	logic [BLK_W-1:0]     map_mem [MAX_GROUPS];
	logic [BLK_W-1:0]     map_rd_q;
	logic                 map_we;

	// Window check on the held request: the borrow marks an index below the window,
	// the last_q compare one above it, the upper offset bits a group past the map.
	logic [32:0]          diff_c;
	logic [31:0]          off_c;
	logic                 range_err_c;
	logic [GRP_W-1:0]     grp_c;

	// Group resolution once the map word is back.
	logic                 present_c;
	logic                 full_c;
	logic [BLK_W-1:0]     blk_c;
	logic [FLAT_W-1:0]    flat_c;
	logic                 is_get;
	logic                 is_set;

	// Entry store connections.
	sgt_wr_t              st_wr;
	logic [FLAT_W-1:0]    val_addr;
	logic [VALUE_WIDTH-1:0] val_wdata;
	logic [VALUE_WIDTH-1:0] val_rdata;
	logic [ROW_AW-1:0]    row_addr;
	logic [ROW_AW-1:0]    wipe_addr;
	logic [ROW_W-1:0]     row_wdata;
	logic [ROW_W-1:0]     row_rdata;
	logic                 hit_c;
	logic [63:0]          rd_wide;

	always_comb begin
		diff_c      = {1'b0, item_q.index} - {1'b0, first_q};
		off_c       = diff_c[31:0];
		range_err_c = diff_c[32] || (item_q.index > last_q) ||
		              (off_c[31:GROUP_SHIFT] >= HI_W'(MAX_GROUPS));
		grp_c       = off_c[GROUP_SHIFT +: GRP_W];
	end

	assign is_get    = (item_q.mode == MODE_GET);
	assign is_set    = (item_q.mode == MODE_SET);
	assign present_c = present_q[grp_q];
	assign full_c    = (next_free_q >= NF_W'(POOL_GROUPS));
	assign blk_c     = present_c ? map_rd_q : BLK_W'(next_free_q);
	assign flat_c    = {blk_c, pos_q};
	assign map_we    = (state_q == S_MAP) && is_set && !present_c && !full_c;

	always_ff @(posedge clk) begin
		if (map_we) begin
			map_mem[grp_q] <= BLK_W'(next_free_q);
		end
		map_rd_q <= map_mem[grp_c];
	end

	// The block sits in the upper bits of the flat address; its rows are contiguous.
	assign wipe_addr = (ROW_AW'(flat_q[FLAT_W-1:GROUP_SHIFT]) << (GROUP_SHIFT - VSH)) +
	                   ROW_AW'(wipe_q);

	always_comb begin
		st_wr.value_we = (state_q == S_SETWR);
		st_wr.row_we   = (state_q == S_WIPE) || (state_q == S_SETWR);
		val_addr       = (state_q == S_MAP) ? flat_c : flat_q;
		case (state_q)
			S_MAP:   row_addr = flat_c[FLAT_W-1:VSH];
			S_WIPE:  row_addr = wipe_addr;
			default: row_addr = flat_q[FLAT_W-1:VSH];
		endcase
		if (state_q == S_WIPE) begin
			row_wdata = '0;
		end else begin
			row_wdata = row_rdata | (ROW_W'(1) << flat_q[VSH-1:0]);
		end
		val_wdata = VALUE_WIDTH'(64'(item_q.write_value));
		hit_c     = row_rdata[flat_q[VSH-1:0]];
		rd_wide   = 64'(val_rdata);
	end

	sgt_store #(
		.GROUP_SHIFT (GROUP_SHIFT),
		.POOL_GROUPS (POOL_GROUPS),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_store (
		.clk       (clk),
		.wr        (st_wr),
		.val_addr  (val_addr),
		.val_wdata (val_wdata),
		.val_rdata (val_rdata),
		.row_addr  (row_addr),
		.row_wdata (row_wdata),
		.row_rdata (row_rdata)
	);

	assign req_ready = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Sequencer, window registers, pool bookkeeping and the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			item_q      <= '0;
			first_q     <= FIRST_RESET;
			last_q      <= LAST_RESET;
			present_q   <= '0;
			next_free_q <= '0;
			grp_q       <= '0;
			pos_q       <= '0;
			flat_q      <= '0;
			wipe_q      <= '0;
			status_q    <= ST_OK;
			rval_q      <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_FIRST) begin
					first_q <= cfg_data;
				end else if (cfg_index == REG_LAST) begin
					last_q <= cfg_data;
				end
			end

			// In S_RESP the result register load below handles the drain as well.
			if (rsp_valid_q && rsp_ready && (state_q != S_RESP)) begin
				rsp_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						item_q  <= req;
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					grp_q    <= grp_c;
					pos_q    <= off_c[GROUP_SHIFT-1:0];
					status_q <= ST_OK;
					rval_q   <= '0;
					if (item_q.mode == MODE_CLEAR) begin
						present_q   <= '0;
						next_free_q <= '0;
						state_q     <= S_RESP;
					end else if (!is_get && !is_set) begin
						state_q <= S_RESP;
					end else if (range_err_c) begin
						status_q <= ST_RANGE;
						state_q  <= S_RESP;
					end else begin
						state_q <= S_MAP;
					end
				end
				S_MAP: begin
					flat_q <= flat_c;
					if (is_get) begin
						if (present_c) begin
							state_q <= S_READ;
						end else begin
							status_q <= ST_NODATA;
							state_q  <= S_RESP;
						end
					end else if (present_c) begin
						state_q <= S_SETWR;
					end else if (full_c) begin
						status_q <= ST_NOMEM;
						state_q  <= S_RESP;
					end else begin
						// A fresh block: claim it, then wipe its valid rows.
						present_q[grp_q] <= 1'b1;
						next_free_q      <= next_free_q + NF_W'(1);
						wipe_q           <= '0;
						state_q          <= S_WIPE;
					end
				end
				S_WIPE: begin
					wipe_q <= wipe_q + WIPE_W'(1);
					if (wipe_q == WIPE_LAST) begin
						state_q <= S_FETCH;
					end
				end
				S_FETCH: begin
					state_q <= S_SETWR;
				end
				S_READ: begin
					if (hit_c) begin
						rval_q <= rd_wide[31:0];
					end else begin
						status_q <= ST_NODATA;
					end
					state_q <= S_RESP;
				end
				S_SETWR: begin
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (!rsp_valid_q || rsp_ready) begin
						rsp_valid_q       <= 1'b1;
						rsp_q.status      <= status_q;
						rsp_q.read_value  <= rval_q;
						state_q           <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
